/* rtl/core/wtosc_pkg.sv */
// Package for the wavetable oscillator.
// Holds the request opcode type and the fixed field widths and constants.
// No dependencies.
package wtosc_pkg;

   typedef enum logic [1:0] {
      OP_GENERATE    = 2'd0,
      OP_WRITE       = 2'd1,
      OP_PHASE_RESET = 2'd2
   } opcode_type;

   localparam int SAMPLE_W     = 16;
   localparam int FREQ_W       = 32;
   localparam int RATE_W       = 32;
   localparam int INTERP_W     = 16;
   localparam int PRODUCT_FRAC = 36;
   localparam int FIFO_DEPTH   = 8;

   localparam logic [RATE_W-1:0] RATE_RESET = 32'd402653;

endpackage

/* rtl/core/wavetable_oscillator_linear_interp.sv */
// Wavetable oscillator with linear interpolation between adjacent table entries.
// Uses wtosc_pkg and two instances of wtosc_ram holding identical table copies.
//
// Usage:
// The request channel (req_valid, req_stall) carries one opcode per request.
// A generate request returns one interpolated sample on the response channel
// (rsp_valid, rsp_stall); table writes and phase resets return nothing.
// A generate request passes the registered stages a, b and c and is written into
// the response queue; it shows on rsp_sample once no earlier samples wait ahead of it.
// The block takes one request every cycle while req_stall is low. Each table
// read hits both RAM copies in the same cycle, one at the integer phase and one
// at the next entry, and the phase add closes through the phase_ff register
// alone, so nothing limits the rate except the eight-entry response queue.
// When the receiver stalls, samples collect in that queue; req_stall rises
// once eight generate requests are in flight or waiting, and falls as soon
// as a sample is taken.
// Reset clears the phase, the pipeline and the queue and loads the default
// rate constant. The table contents are undefined until written, and the
// guard entry at index TABLE_ENTRIES must be written as a copy of entry 0.
// csr_write_data loads the rate constant at any edge with csr_write_enable.
module wavetable_oscillator_linear_interp
   import wtosc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024,
   parameter int FRACTION_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic [$clog2(TABLE_ENTRIES):0]      req_table_index,
   input  logic signed [SAMPLE_W-1:0]          req_table_value,
   input  logic signed [FREQ_W-1:0]            req_frequency,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [SAMPLE_W-1:0]          rsp_sample,
   input  logic                                csr_write_enable,
   input  logic [RATE_W-1:0]                   csr_write_data
);

   localparam int IDX_W     = $clog2(TABLE_ENTRIES);
   localparam int ADDR_W    = IDX_W + 1;
   localparam int PHASE_W   = IDX_W + FRACTION_BITS;
   localparam int INC_SHIFT = PRODUCT_FRAC - FRACTION_BITS;
   localparam int MUL_W     = FREQ_W + RATE_W;
   localparam int DIFF_W    = SAMPLE_W + 1;
   localparam int PROD_W    = DIFF_W + INTERP_W + 1;
   localparam int PTR_W     = $clog2(FIFO_DEPTH);
   localparam int CNT_W     = PTR_W + 1;

   localparam logic [ADDR_W-1:0] GUARD_INDEX = ADDR_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0]  FIFO_FULL   = CNT_W'(FIFO_DEPTH);

   logic [RATE_W-1:0]           rate_ff;
   logic [PHASE_W-1:0]          phase_ff, phase_in;

   logic                        a_valid_ff;
   opcode_type                  a_op_ff;
   logic [ADDR_W-1:0]           a_index_ff;
   logic [SAMPLE_W-1:0]         a_value_ff;
   logic [PHASE_W-1:0]          a_inc_ff, a_inc_in;

   logic                        b_valid_ff, b_valid_in;
   logic [INTERP_W-1:0]         b_frac_ff, b_frac_in;

   logic                        c_valid_ff;
   logic signed [PROD_W-1:0]    c_prod_ff, c_prod_in;
   logic signed [SAMPLE_W-1:0]  c_base_ff;

   logic signed [SAMPLE_W-1:0]  fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]            wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]            fill_ff, fill_in;
   logic [CNT_W-1:0]            out_cnt_ff, out_cnt_in;

   logic                        req_accept, gen_accept, pop;
   logic signed [MUL_W:0]       mul_full;
   logic                        table_wr, table_rd;
   logic [ADDR_W-1:0]           rd_addr0, rd_addr1;
   logic [SAMPLE_W-1:0]         rd_data0, rd_data1;
   logic signed [DIFF_W-1:0]    diff;
   logic signed [PROD_W-1:0]    step_full;
   logic signed [DIFF_W-1:0]    sum;

   assign req_stall  = (out_cnt_ff == FIFO_FULL);
   assign req_accept = req_valid && !req_stall;
   assign gen_accept = req_accept && (opcode_type'(req_opcode) == OP_GENERATE);
   assign pop        = rsp_valid && !rsp_stall;

   // Phase increment: signed frequency times unsigned rate, floored into phase units.
   assign mul_full = $signed(req_frequency) * $signed({1'b0, rate_ff});
   assign a_inc_in = PHASE_W'($signed(mul_full[MUL_W-1:0]) >>> INC_SHIFT);

   always_comb begin
      phase_in = phase_ff;
      if (a_valid_ff) begin
         unique case (a_op_ff)
            OP_GENERATE:    phase_in = phase_ff + a_inc_ff;
            OP_PHASE_RESET: phase_in = '0;
            default:        phase_in = phase_ff;
         endcase
      end
   end

   assign table_wr   = a_valid_ff && (a_op_ff == OP_WRITE) && (a_index_ff <= GUARD_INDEX);
   assign table_rd   = a_valid_ff && (a_op_ff == OP_GENERATE);
   assign rd_addr0   = {1'b0, phase_ff[PHASE_W-1:FRACTION_BITS]};
   assign rd_addr1   = rd_addr0 + ADDR_W'(1);
   assign b_valid_in = table_rd;
   assign b_frac_in  = phase_ff[FRACTION_BITS-1 -: INTERP_W];

   wtosc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_ENTRIES + 1)
   ) u_ram_lo (
      .clock   (clock),
      .wr_en   (table_wr),
      .wr_addr (a_index_ff),
      .wr_data (a_value_ff),
      .rd_en   (table_rd),
      .rd_addr (rd_addr0),
      .rd_data (rd_data0)
   );

   wtosc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TABLE_ENTRIES + 1)
   ) u_ram_hi (
      .clock   (clock),
      .wr_en   (table_wr),
      .wr_addr (a_index_ff),
      .wr_data (a_value_ff),
      .rd_en   (table_rd),
      .rd_addr (rd_addr1),
      .rd_data (rd_data1)
   );

   assign diff      = $signed({rd_data1[SAMPLE_W-1], rd_data1})
                    - $signed({rd_data0[SAMPLE_W-1], rd_data0});
   assign c_prod_in = PROD_W'(diff) * PROD_W'($signed({1'b0, b_frac_ff}));

   // The arithmetic shift floors the step, and the sum always lies between the two entries.
   assign step_full = c_prod_ff >>> INTERP_W;
   assign sum       = $signed({c_base_ff[SAMPLE_W-1], c_base_ff}) + step_full[DIFF_W-1:0];

   always_comb begin
      fill_in = fill_ff;
      if (c_valid_ff && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (!c_valid_ff && pop) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (gen_accept && !pop) begin
         out_cnt_in = out_cnt_ff + CNT_W'(1);
      end else if (!gen_accept && pop) begin
         out_cnt_in = out_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= RATE_RESET;
         phase_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         fill_ff    <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            rate_ff <= csr_write_data;
         end
         phase_ff   <= phase_in;
         a_valid_ff <= req_accept;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= b_valid_ff;
         if (c_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         fill_ff    <= fill_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff    <= opcode_type'(req_opcode);
      a_index_ff <= req_table_index;
      a_value_ff <= req_table_value;
      a_inc_ff   <= a_inc_in;
      b_frac_ff  <= b_frac_in;
      c_prod_ff  <= c_prod_in;
      c_base_ff  <= $signed(rd_data0);
      if (c_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= sum[SAMPLE_W-1:0];
      end
   end

   assign rsp_valid  = (fill_ff != '0);
   assign rsp_sample = fifo_ff[rd_ptr_ff];

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (out_cnt_ff <= FIFO_FULL) && (fill_ff <= out_cnt_ff))
      else $error("response credit count out of bounds");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> (fill_ff != FIFO_FULL) || pop)
      else $error("sample pushed into a full response queue");

   a_phase_clear: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && (a_op_ff == OP_PHASE_RESET) |=> (phase_ff == '0))
      else $error("phase not cleared by a phase reset request");

   a_gen_in_flight: assert property (@(posedge clock) disable iff (reset)
      gen_accept |=> a_valid_ff && (a_op_ff == OP_GENERATE) && (out_cnt_ff != '0))
      else $error("accepted generate request lost from the pipeline");

endmodule

/* rtl/core/wtosc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module wtosc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
